/* hdl/udsr_pkg.sv */
// Shared constants and state types for the URL path dot-segment remover.
package udsr_pkg;

	localparam int OP_W        = 2;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 9;
	localparam int STAT_W      = 2;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_PAD_W   = OUT_TDATA_W - BYTE_W - LEN_W - STAT_W;

	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [STAT_W-1:0] ST_PAST_END = 2'd2;

	localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;

	typedef enum logic [2:0] {
		TS_IDLE,
		TS_REDUCE,
		TS_DONE,
		TS_RD_WAIT,
		TS_RD_END
	} top_state_t;

	typedef enum logic [2:0] {
		RS_IDLE,
		RS_FILL,
		RS_FILL_WAIT,
		RS_SCAN,
		RS_DROP,
		RS_DROP_WAIT
	} red_state_t;

endpackage

/* hdl/udsr_store.sv */
// Path byte store: one write port, one read port with registered read data.
module udsr_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [udsr_pkg::BYTE_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [udsr_pkg::BYTE_W-1:0] rd_data
);

	logic [udsr_pkg::BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/udsr_reducer.sv */
// In-place dot-segment reduction sequencer over the path store.
module udsr_reducer #(
	parameter int CNT_W         = 9,
	parameter int AW            = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [CNT_W-1:0]            n,
	output logic                        done,
	output logic [CNT_W-1:0]            len,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	input  logic [udsr_pkg::BYTE_W-1:0] rd_data,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [udsr_pkg::BYTE_W-1:0] wr_data
);

	udsr_pkg::red_state_t state_q, state_d;

	logic [CNT_W-1:0] n_q, n_d;
	logic [CNT_W-1:0] r_q, r_d;
	logic [CNT_W-1:0] f_q, f_d;
	logic [CNT_W-1:0] w_q, w_d;
	logic [2:0]       wv_q, wv_d;
	logic             copy_q, copy_d;
	logic [udsr_pkg::BYTE_W-1:0] win_q [4];
	logic [udsr_pkg::BYTE_W-1:0] win_d [4];

	logic [CNT_W-1:0] left;
	logic [CNT_W-1:0] w_dec;
	logic [1:0]       k;
	logic             do_copy, set_slash, do_drop;
	logic             eq1, eq2, eq3, ge2, ge3, ge4;
	logic [udsr_pkg::BYTE_W-1:0] c0, c1, c2, c3;

	assign left  = n_q - r_q;
	assign w_dec = w_q - CNT_W'(1);
	assign eq1   = left == CNT_W'(1);
	assign eq2   = left == CNT_W'(2);
	assign eq3   = left == CNT_W'(3);
	assign ge2   = left >= CNT_W'(2);
	assign ge3   = left >= CNT_W'(3);
	assign ge4   = left >= CNT_W'(4);
	assign c0    = win_q[0];
	assign c1    = win_q[1];
	assign c2    = win_q[2];
	assign c3    = win_q[3];
	assign len   = w_q;

	// pick the rewrite rule for the bytes at the read position
	always_comb begin
		k         = 2'd1;
		do_copy   = 1'b0;
		set_slash = 1'b0;
		do_drop   = 1'b0;
		priority if (copy_q && c0 != udsr_pkg::CHAR_SLASH) begin
			do_copy = 1'b1;
		end else if (ge2 && c0 == udsr_pkg::CHAR_DOT && c1 == udsr_pkg::CHAR_SLASH) begin
			k = 2'd2;
		end else if (ge3 && c0 == udsr_pkg::CHAR_DOT && c1 == udsr_pkg::CHAR_DOT &&
				c2 == udsr_pkg::CHAR_SLASH) begin
			k = 2'd3;
		end else if (ge3 && c0 == udsr_pkg::CHAR_SLASH && c1 == udsr_pkg::CHAR_DOT &&
				c2 == udsr_pkg::CHAR_SLASH) begin
			k = 2'd2;
		end else if (eq2 && c0 == udsr_pkg::CHAR_SLASH && c1 == udsr_pkg::CHAR_DOT) begin
			k         = 2'd1;
			set_slash = 1'b1;
		end else if (ge4 && c0 == udsr_pkg::CHAR_SLASH && c1 == udsr_pkg::CHAR_DOT &&
				c2 == udsr_pkg::CHAR_DOT && c3 == udsr_pkg::CHAR_SLASH) begin
			k       = 2'd3;
			do_drop = 1'b1;
		end else if (eq3 && c0 == udsr_pkg::CHAR_SLASH && c1 == udsr_pkg::CHAR_DOT &&
				c2 == udsr_pkg::CHAR_DOT) begin
			k         = 2'd2;
			set_slash = 1'b1;
			do_drop   = 1'b1;
		end else if (eq1 && c0 == udsr_pkg::CHAR_DOT) begin
			k = 2'd1;
		end else if (eq2 && c0 == udsr_pkg::CHAR_DOT && c1 == udsr_pkg::CHAR_DOT) begin
			k = 2'd2;
		end else begin
			do_copy = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		n_d     = n_q;
		r_d     = r_q;
		f_d     = f_q;
		w_d     = w_q;
		wv_d    = wv_q;
		copy_d  = copy_q;
		win_d   = win_q;
		done    = 1'b0;
		rd_en   = 1'b0;
		rd_addr = f_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = w_q[AW-1:0];
		wr_data = c0;
		unique case (state_q)
			udsr_pkg::RS_IDLE: begin
				if (start) begin
					n_d     = n;
					r_d     = '0;
					f_d     = '0;
					w_d     = '0;
					wv_d    = '0;
					copy_d  = 1'b0;
					state_d = udsr_pkg::RS_FILL;
				end
			end
			udsr_pkg::RS_FILL: begin
				// window holds min(4, left) bytes from the read position
				if (wv_q == 3'd4 || f_q == n_q) begin
					state_d = udsr_pkg::RS_SCAN;
				end else begin
					rd_en   = 1'b1;
					state_d = udsr_pkg::RS_FILL_WAIT;
				end
			end
			udsr_pkg::RS_FILL_WAIT: begin
				win_d[wv_q[1:0]] = rd_data;
				wv_d             = wv_q + 3'd1;
				f_d              = f_q + CNT_W'(1);
				state_d          = udsr_pkg::RS_FILL;
			end
			udsr_pkg::RS_SCAN: begin
				if (left == '0) begin
					done    = 1'b1;
					state_d = udsr_pkg::RS_IDLE;
				end else begin
					if (do_copy) begin
						wr_en = 1'b1;
						w_d   = w_q + CNT_W'(1);
					end
					r_d  = r_q + CNT_W'(k);
					wv_d = wv_q - {1'b0, k};
					unique case (k)
						2'd1: begin
							for (int i = 0; i < 3; i++) win_d[i] = win_q[i+1];
						end
						2'd2: begin
							for (int i = 0; i < 2; i++) win_d[i] = win_q[i+2];
						end
						2'd3: begin
							win_d[0] = win_q[3];
						end
						default: ;
					endcase
					if (set_slash) begin
						win_d[0] = udsr_pkg::CHAR_SLASH;
					end
					copy_d  = do_copy;
					state_d = do_drop ? udsr_pkg::RS_DROP : udsr_pkg::RS_FILL;
				end
			end
			udsr_pkg::RS_DROP: begin
				// walk back over the last output segment
				if (w_q == '0) begin
					state_d = udsr_pkg::RS_FILL;
				end else begin
					rd_en   = 1'b1;
					rd_addr = w_dec[AW-1:0];
					w_d     = w_dec;
					state_d = udsr_pkg::RS_DROP_WAIT;
				end
			end
			udsr_pkg::RS_DROP_WAIT: begin
				state_d = (rd_data == udsr_pkg::CHAR_SLASH) ? udsr_pkg::RS_FILL
						: udsr_pkg::RS_DROP;
			end
			default: state_d = udsr_pkg::RS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= udsr_pkg::RS_IDLE;
			n_q     <= '0;
			r_q     <= '0;
			f_q     <= '0;
			w_q     <= '0;
			wv_q    <= '0;
			copy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			r_q     <= r_d;
			f_q     <= f_d;
			w_q     <= w_d;
			wv_q    <= wv_d;
			copy_q  <= copy_d;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

endmodule

/* hdl/url_path_dot_segment_remover_top.sv */
// Top level: command decode, path store, reduction sequencer and result register.
//
// Input stream (s_*): one transfer per command. s_tuser carries the op:
// append a path byte, finish, or read the next reduced byte; s_tdata
// carries the path byte. Output stream (m_*): one transfer for each finish
// and each read, none for append; m_tlast marks the last reduced byte.
// An append is written to the store as it is accepted. A read goes through
// the store's registered read port and then the result register. A finish
// walks the stored path: it fetches stored bytes into a four-byte window,
// applies the rewrite steps, and walks back over output bytes when a ".."
// segment removes output, stopping at a slash or at the start of the path.
// The store has a single read and a single write port.
// Commands are taken while a result waits in the output register; a command
// that produces a result holds until that register is free, so a stalled
// receiver stops the input after one pending result.
// Reset clears all counters and flags; the store contents are not cleared
// and a read only ever returns bytes written since reset.
module url_path_dot_segment_remover_top #(
	parameter int PATH_CAPACITY = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // [7:0] path_byte
	input  logic [1:0]                          s_tuser,  // [1:0] op
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [udsr_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [7:0] out_byte, [16:8] out_length,
	                                                      // [18:17] status, [23:19] zero
	output logic                                m_tlast   // out_last
);

	localparam int CNT_W = $clog2(PATH_CAPACITY + 1);
	localparam int AW    = $clog2(PATH_CAPACITY);

	udsr_pkg::top_state_t state_q, state_d;

	logic [CNT_W-1:0] ic_q, ic_d;
	logic [CNT_W-1:0] rc_q, rc_d;
	logic [CNT_W-1:0] ri_q, ri_d;
	logic             ovf_q, ovf_d;

	logic                              m_valid_q;
	logic [udsr_pkg::OUT_TDATA_W-1:0]  m_data_q, m_data_d;
	logic                              m_last_q, m_last_d;
	logic                              load_out;

	logic                        accept, slot_free;
	logic [udsr_pkg::OP_W-1:0]   op;
	logic [CNT_W+udsr_pkg::LEN_W-1:0] rc_ext;
	logic [udsr_pkg::LEN_W-1:0]  len_out;

	logic                        top_wr_en, top_rd_en;
	logic [AW-1:0]               top_wr_addr, top_rd_addr;

	logic                        mem_wr_en, mem_rd_en;
	logic [AW-1:0]               mem_wr_addr, mem_rd_addr;
	logic [udsr_pkg::BYTE_W-1:0] mem_wr_data, mem_rd_data;

	logic                        red_start, red_done;
	logic [CNT_W-1:0]            red_len;
	logic                        red_rd_en, red_wr_en;
	logic [AW-1:0]               red_rd_addr, red_wr_addr;
	logic [udsr_pkg::BYTE_W-1:0] red_wr_data;

	assign s_tready  = state_q == udsr_pkg::TS_IDLE;
	assign accept    = s_tvalid && s_tready;
	assign op        = s_tuser;
	assign slot_free = !m_valid_q || m_tready;
	assign rc_ext    = {{udsr_pkg::LEN_W{1'b0}}, rc_q};
	assign len_out   = rc_ext[udsr_pkg::LEN_W-1:0];

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	// the sequencer owns the store while a finish is running
	always_comb begin
		if (state_q == udsr_pkg::TS_REDUCE) begin
			mem_wr_en   = red_wr_en;
			mem_wr_addr = red_wr_addr;
			mem_wr_data = red_wr_data;
			mem_rd_en   = red_rd_en;
			mem_rd_addr = red_rd_addr;
		end else begin
			mem_wr_en   = top_wr_en;
			mem_wr_addr = top_wr_addr;
			mem_wr_data = s_tdata;
			mem_rd_en   = top_rd_en;
			mem_rd_addr = top_rd_addr;
		end
	end

	udsr_store #(
		.DEPTH (PATH_CAPACITY),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	udsr_reducer #(
		.CNT_W         (CNT_W),
		.AW            (AW)
	) u_reducer (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (red_start),
		.n       (ic_q),
		.done    (red_done),
		.len     (red_len),
		.rd_en   (red_rd_en),
		.rd_addr (red_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (red_wr_en),
		.wr_addr (red_wr_addr),
		.wr_data (red_wr_data)
	);

	always_comb begin
		state_d     = state_q;
		ic_d        = ic_q;
		rc_d        = rc_q;
		ri_d        = ri_q;
		ovf_d       = ovf_q;
		top_wr_en   = 1'b0;
		top_wr_addr = ic_q[AW-1:0];
		top_rd_en   = 1'b0;
		top_rd_addr = ri_q[AW-1:0];
		red_start   = 1'b0;
		load_out    = 1'b0;
		m_data_d    = m_data_q;
		m_last_d    = m_last_q;
		unique case (state_q)
			udsr_pkg::TS_IDLE: begin
				if (accept) begin
					unique case (op)
						udsr_pkg::OP_APPEND: begin
							if (ic_q < CNT_W'(PATH_CAPACITY)) begin
								top_wr_en = 1'b1;
								ic_d      = ic_q + CNT_W'(1);
							end else begin
								ovf_d = 1'b1;
							end
						end
						udsr_pkg::OP_FINISH: begin
							red_start = 1'b1;
							state_d   = udsr_pkg::TS_REDUCE;
						end
						udsr_pkg::OP_READ: begin
							if (ri_q < rc_q) begin
								top_rd_en = 1'b1;
								state_d   = udsr_pkg::TS_RD_WAIT;
							end else begin
								state_d = udsr_pkg::TS_RD_END;
							end
						end
						default: ;
					endcase
				end
			end
			udsr_pkg::TS_REDUCE: begin
				// rewind the read position together with the new length
				if (red_done) begin
					rc_d    = red_len;
					ri_d    = '0;
					state_d = udsr_pkg::TS_DONE;
				end
			end
			udsr_pkg::TS_DONE: begin
				if (slot_free) begin
					load_out = 1'b1;
					m_data_d = {{udsr_pkg::OUT_PAD_W{1'b0}},
						ovf_q ? udsr_pkg::ST_OVERFLOW : udsr_pkg::ST_OK,
						len_out, {udsr_pkg::BYTE_W{1'b0}}};
					m_last_d = 1'b0;
					ic_d     = '0;
					ovf_d    = 1'b0;
					ri_d     = '0;
					state_d  = udsr_pkg::TS_IDLE;
				end
			end
			udsr_pkg::TS_RD_WAIT: begin
				if (slot_free) begin
					load_out = 1'b1;
					m_data_d = {{udsr_pkg::OUT_PAD_W{1'b0}}, udsr_pkg::ST_OK,
						len_out, mem_rd_data};
					m_last_d = (ri_q + CNT_W'(1)) == rc_q;
					ri_d     = ri_q + CNT_W'(1);
					state_d  = udsr_pkg::TS_IDLE;
				end
			end
			udsr_pkg::TS_RD_END: begin
				if (slot_free) begin
					load_out = 1'b1;
					m_data_d = {{udsr_pkg::OUT_PAD_W{1'b0}}, udsr_pkg::ST_PAST_END,
						len_out, {udsr_pkg::BYTE_W{1'b0}}};
					m_last_d = 1'b0;
					state_d  = udsr_pkg::TS_IDLE;
				end
			end
			default: state_d = udsr_pkg::TS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= udsr_pkg::TS_IDLE;
			ic_q      <= '0;
			rc_q      <= '0;
			ri_q      <= '0;
			ovf_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ic_q    <= ic_d;
			rc_q    <= rc_d;
			ri_q    <= ri_d;
			ovf_q   <= ovf_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		m_data_q <= m_data_d;
		m_last_q <= m_last_d;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ic_q <= CNT_W'(PATH_CAPACITY) && rc_q <= CNT_W'(PATH_CAPACITY))
		else $error("stored or reduced length exceeds capacity");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ri_q <= rc_q)
		else $error("read position beyond reduced length");

	a_done_in_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		red_done |-> state_q == udsr_pkg::TS_REDUCE)
		else $error("reduction finished outside a finish command");

	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		red_done |=> state_q == udsr_pkg::TS_DONE && rc_q == $past(red_len))
		else $error("reduced length not captured after reduction");

endmodule
